// ----- rtl/uspcm_pkg.sv -----
`default_nettype none

package uspcm_pkg;

  // Node type and subtype codes
  localparam logic [7:0] TYPE_MESSAGING = 8'h03;
  localparam logic [7:0] SUB_USB_CLASS  = 8'h0F;
  localparam logic [7:0] SUB_USB_WWID   = 8'h10;
  localparam logic [7:0] TYPE_END       = 8'h7F;

  // Result outcome codes
  localparam logic [2:0] OUT_NONE      = 3'd0;
  localparam logic [2:0] OUT_MATCH     = 3'd1;
  localparam logic [2:0] OUT_MISMATCH  = 3'd2;
  localparam logic [2:0] OUT_WWID      = 3'd3;
  localparam logic [2:0] OUT_MALFORMED = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_VENDOR    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_PRODUCT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_CLASS     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_SUBCLASS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_PROTOCOL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTF_CLASS    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTF_SUBCLASS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTF_PROTOCOL = 4'd7;

  // Byte offsets within a node
  localparam logic [15:0] OFF_TYPE     = 16'd0;
  localparam logic [15:0] OFF_SUBTYPE  = 16'd1;
  localparam logic [15:0] OFF_LEN_LO   = 16'd2;
  localparam logic [15:0] OFF_LEN_HI   = 16'd3;
  localparam logic [15:0] OFF_VID_LO   = 16'd4;
  localparam logic [15:0] OFF_VID_HI   = 16'd5;
  localparam logic [15:0] OFF_PID_LO   = 16'd6;
  localparam logic [15:0] OFF_PID_HI   = 16'd7;
  localparam logic [15:0] OFF_CLASS    = 16'd8;
  localparam logic [15:0] OFF_SUBCLASS = 16'd9;
  localparam logic [15:0] OFF_PROTOCOL = 16'd10;

  localparam logic [15:0] HDR_LEN       = 16'd4;
  localparam logic [15:0] CLASS_NODE_LEN = 16'd11;

  // Wildcards and the interface-association triple
  localparam logic [15:0] WILD_ID    = 16'hFFFF;
  localparam logic [7:0]  WILD_CLASS = 8'hFF;
  localparam logic [7:0]  IAD_CLASS    = 8'hEF;
  localparam logic [7:0]  IAD_SUBCLASS = 8'h02;
  localparam logic [7:0]  IAD_PROTOCOL = 8'h01;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  dev_class;
    logic [7:0]  dev_subclass;
    logic [7:0]  dev_protocol;
    logic [7:0]  intf_class;
    logic [7:0]  intf_subclass;
    logic [7:0]  intf_protocol;
  } dev_cfg_t;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  cls;
    logic [7:0]  subcls;
    logic [7:0]  proto;
  } cap_node_t;

endpackage

`default_nettype wire

// ----- rtl/uspcm_class_cmp.sv -----
`default_nettype none

// Compares a captured USB class node with the configured device.
module uspcm_class_cmp (
  input  var uspcm_pkg::dev_cfg_t  cfg,
  input  var uspcm_pkg::cap_node_t cap,
  output logic                     match
);

  logic       id_ok;
  logic       defer;
  logic [7:0] want_c;
  logic [7:0] want_s;
  logic [7:0] want_p;
  logic       cls_ok;

  always_comb begin
    id_ok = (cap.vendor == uspcm_pkg::WILD_ID || cap.vendor == cfg.vendor) &&
            (cap.product == uspcm_pkg::WILD_ID || cap.product == cfg.product);

    // class 0 or the IAD triple defers to the interface descriptor
    defer = (cfg.dev_class == 8'h00) ||
            (cfg.dev_class == uspcm_pkg::IAD_CLASS &&
             cfg.dev_subclass == uspcm_pkg::IAD_SUBCLASS &&
             cfg.dev_protocol == uspcm_pkg::IAD_PROTOCOL);

    want_c = defer ? cfg.intf_class    : cfg.dev_class;
    want_s = defer ? cfg.intf_subclass : cfg.dev_subclass;
    want_p = defer ? cfg.intf_protocol : cfg.dev_protocol;

    cls_ok = (cap.cls == uspcm_pkg::WILD_CLASS || cap.cls == want_c) &&
             (cap.subcls == uspcm_pkg::WILD_CLASS || cap.subcls == want_s) &&
             (cap.proto == uspcm_pkg::WILD_CLASS || cap.proto == want_p);

    match = id_ok && cls_ok;
  end

endmodule

`default_nettype wire

// ----- rtl/usb_short_path_class_matcher.sv -----
`default_nettype none

// Channel   Direction  Payload                      Handshake
// in_       request    path_byte[7:0], last_byte    in_valid / in_ready
// out_      result     matched, outcome[2:0]        out_valid / out_ready
// cfg_      write      index[3:0], wdata[15:0]      cfg_wr_en, no wait
//
// One byte per cycle sustained. A request lands in the input register, the
// node walker updates its state from that register when the request advances,
// and a result (only for a request marked last) moves to the output register.
// out_valid rises when the output register loads a last-marked request's result.
// Reset (rst_n low, synchronous) clears walker state, config and both stages.
// A stalled result holds back only a last-marked request and any input behind it.
module usb_short_path_class_matcher (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_path_byte,
  input  wire logic        in_last_byte,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_matched,
  output logic [2:0]       out_outcome,

  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  uspcm_pkg::dev_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        uspcm_pkg::REG_DEV_VENDOR:    cfg_r.vendor        <= cfg_wdata;
        uspcm_pkg::REG_DEV_PRODUCT:   cfg_r.product       <= cfg_wdata;
        uspcm_pkg::REG_DEV_CLASS:     cfg_r.dev_class     <= cfg_wdata[7:0];
        uspcm_pkg::REG_DEV_SUBCLASS:  cfg_r.dev_subclass  <= cfg_wdata[7:0];
        uspcm_pkg::REG_DEV_PROTOCOL:  cfg_r.dev_protocol  <= cfg_wdata[7:0];
        uspcm_pkg::REG_INTF_CLASS:    cfg_r.intf_class    <= cfg_wdata[7:0];
        uspcm_pkg::REG_INTF_SUBCLASS: cfg_r.intf_subclass <= cfg_wdata[7:0];
        uspcm_pkg::REG_INTF_PROTOCOL: cfg_r.intf_protocol <= cfg_wdata[7:0];
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  // a non-last byte never produces a result, so it never waits on out_ready
  assign s1_adv   = s1_vld_r && (!s1_last_r || !out_valid || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_path_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Node walker state
  // ---------------------------------------------------------------------
  logic [15:0]          offset_r,  offset_nxt;
  logic [15:0]          length_r,  length_nxt;
  logic [7:0]           type_r,    type_nxt;
  logic [7:0]           subtype_r, subtype_nxt;
  uspcm_pkg::cap_node_t cap_r,     cap_nxt;
  logic                 decided_r, decided_nxt;
  logic [2:0]           held_r,    held_nxt;

  logic                 cls_match;
  logic                 node_end;
  logic [2:0]           res_outcome;

  // match is judged on the capture including the current byte
  uspcm_class_cmp u_cmp (
    .cfg   (cfg_r),
    .cap   (cap_nxt),
    .match (cls_match)
  );

  always_comb begin
    offset_nxt  = offset_r;
    length_nxt  = length_r;
    type_nxt    = type_r;
    subtype_nxt = subtype_r;
    cap_nxt     = cap_r;
    decided_nxt = decided_r;
    held_nxt    = held_r;
    node_end    = 1'b0;

    if (!decided_r) begin
      case (offset_r)
        uspcm_pkg::OFF_TYPE:     type_nxt          = s1_byte_r;
        uspcm_pkg::OFF_SUBTYPE:  subtype_nxt       = s1_byte_r;
        uspcm_pkg::OFF_LEN_LO:   length_nxt[7:0]   = s1_byte_r;
        uspcm_pkg::OFF_LEN_HI:   length_nxt[15:8]  = s1_byte_r;
        uspcm_pkg::OFF_VID_LO:   cap_nxt.vendor[7:0]   = s1_byte_r;
        uspcm_pkg::OFF_VID_HI:   cap_nxt.vendor[15:8]  = s1_byte_r;
        uspcm_pkg::OFF_PID_LO:   cap_nxt.product[7:0]  = s1_byte_r;
        uspcm_pkg::OFF_PID_HI:   cap_nxt.product[15:8] = s1_byte_r;
        uspcm_pkg::OFF_CLASS:    cap_nxt.cls       = s1_byte_r;
        uspcm_pkg::OFF_SUBCLASS: cap_nxt.subcls    = s1_byte_r;
        uspcm_pkg::OFF_PROTOCOL: cap_nxt.proto     = s1_byte_r;
        default: ; // payload beyond the class fields is skipped
      endcase

      node_end = (offset_r >= uspcm_pkg::OFF_LEN_HI) &&
                 ({1'b0, offset_r} + 17'd1 == {1'b0, length_nxt});

      if (offset_r == uspcm_pkg::OFF_LEN_HI && length_nxt < uspcm_pkg::HDR_LEN) begin
        // length field below the header size
        decided_nxt = 1'b1;
        held_nxt    = uspcm_pkg::OUT_MALFORMED;
      end else if (node_end) begin
        if (type_r == uspcm_pkg::TYPE_MESSAGING && subtype_r == uspcm_pkg::SUB_USB_CLASS) begin
          decided_nxt = 1'b1;
          held_nxt    = (length_nxt >= uspcm_pkg::CLASS_NODE_LEN && cls_match) ?
                        uspcm_pkg::OUT_MATCH : uspcm_pkg::OUT_MISMATCH;
        end else if (type_r == uspcm_pkg::TYPE_MESSAGING &&
                     subtype_r == uspcm_pkg::SUB_USB_WWID) begin
          decided_nxt = 1'b1;
          held_nxt    = uspcm_pkg::OUT_WWID;
        end else if (type_r == uspcm_pkg::TYPE_END) begin
          decided_nxt = 1'b1;
          held_nxt    = uspcm_pkg::OUT_NONE;
        end else begin
          // uninteresting node: start fresh on the next header
          offset_nxt  = '0;
          length_nxt  = '0;
          type_nxt    = '0;
          subtype_nxt = '0;
          cap_nxt     = '0;
        end
      end else begin
        offset_nxt = offset_r + 16'd1;
      end
    end

    // end of stream: a decided outcome is reported; otherwise a node cut short
    // after its header is malformed, and a partial header is simply ignored
    if (decided_nxt) begin
      res_outcome = held_nxt;
    end else if (offset_nxt >= uspcm_pkg::HDR_LEN) begin
      res_outcome = uspcm_pkg::OUT_MALFORMED;
    end else begin
      res_outcome = uspcm_pkg::OUT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      length_r  <= '0;
      type_r    <= '0;
      subtype_r <= '0;
      cap_r     <= '0;
      decided_r <= 1'b0;
      held_r    <= uspcm_pkg::OUT_NONE;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        // path finished: clear for the next one
        offset_r  <= '0;
        length_r  <= '0;
        type_r    <= '0;
        subtype_r <= '0;
        cap_r     <= '0;
        decided_r <= 1'b0;
        held_r    <= uspcm_pkg::OUT_NONE;
      end else begin
        offset_r  <= offset_nxt;
        length_r  <= length_nxt;
        type_r    <= type_nxt;
        subtype_r <= subtype_nxt;
        cap_r     <= cap_nxt;
        decided_r <= decided_nxt;
        held_r    <= held_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic       out_load;
  logic       out_vld_r;
  logic       out_matched_r;
  logic [2:0] out_outcome_r;

  assign out_load = s1_adv && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched_r <= (res_outcome == uspcm_pkg::OUT_MATCH);
      out_outcome_r <= res_outcome;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_matched = out_matched_r;
  assign out_outcome = out_outcome_r;

endmodule

`default_nettype wire
